@@ hw/rtl/ptes_pkg.sv @@
package ptes_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);

  // Quotient bits of the scale division; |end - start| fits in 17 bits.
  localparam int DIV_STEPS = 17;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_REC    = 2'd0,
    ST_ADD_OK = 2'd1,
    ST_FULL   = 2'd2,
    ST_NONE   = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] age;
    logic [15:0] life;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] az;
    logic [31:0] scale;
  } rec_t;

  typedef struct packed {
    logic shift_up;
    logic shift_dn;
    logic wr_sel;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/ptes_if.sv @@
interface ptes_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic        [15:0] life_frames;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic signed [31:0] acc_z;
  logic        [31:0] scale_pair;

  modport source (output valid, opcode, life_frames, pos_x, pos_y, pos_z, vel_x, vel_y,
                  vel_z, acc_x, acc_y, acc_z, scale_pair, input ready);
  modport sink (input valid, opcode, life_frames, pos_x, pos_y, pos_z, vel_x, vel_y,
                vel_z, acc_x, acc_y, acc_z, scale_pair, output ready);
endinterface

interface ptes_out_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [15:0] out_scale;
  logic               last;

  modport source (output valid, status, out_x, out_y, out_z, out_scale, last, input ready);
  modport sink (input valid, status, out_x, out_y, out_z, out_scale, last, output ready);
endinterface

@@ hw/rtl/ptes_cell.sv @@
module ptes_cell (
  input  logic                clk_i,
  input  ptes_pkg::cell_ctrl_t ctrl_i,
  input  ptes_pkg::rec_t      up_i,
  input  ptes_pkg::rec_t      dn_i,
  input  ptes_pkg::rec_t      wr_i,
  output ptes_pkg::rec_t      rec_o
);

  ptes_pkg::rec_t rec_q;

  // An add pushes the chain toward the back; a tick walk pulls it toward the front.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_up) begin
      rec_q <= up_i;
    end else if (ctrl_i.shift_dn) begin
      rec_q <= ctrl_i.wr_sel ? wr_i : dn_i;
    end
  end

  assign rec_o = rec_q;

endmodule

@@ hw/rtl/ptes_div.sv @@
module ptes_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [16:0] quot_o
);

  logic [15:0]                    rem_q;
  logic [16:0]                    q_q;
  logic [ptes_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic [17:0]                    trial;

  assign trial = {1'b0, rem_q, q_q[16]} - {2'b00, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ptes_pkg::DIV_CNT_W'(ptes_pkg::DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ptes_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restoring division, one quotient bit per cycle. The quotient fits in 17 bits, so the
  // upper dividend bits start out below the divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[32:17];
      q_q   <= dividend_i[16:0];
    end else if (busy_q) begin
      rem_q <= trial[17] ? {rem_q[14:0], q_q[16]} : trial[15:0];
      q_q   <= {q_q[15:0], ~trial[17]};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

@@ hw/rtl/particle_table_euler_step_core.sv @@
// Channel | Port  | Beat carries
// input   | in_i  | opcode, life_frames, pos/vel/acc xyz, scale_pair
// output  | out_o | status, out_x/y/z, out_scale, last
//
// An add registers the status beat and, unless the table is full, shifts the cell chain
// back by one. A tick first scans the table, compacting it, and then walks it again,
// one particle at a time: the Euler step and the scale product, the divider load, the
// division (17 quotient bits, then the done flag), and the emit. A tick that finds no
// live particle emits one status beat instead.
// Reset clears the count, the control and the output register; cells hold no reset.
// A stalled output holds the walk at its emit step.
module particle_table_euler_step_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptes_in_if.sink     in_i,
  ptes_out_if.source  out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_DLD,
    S_DIV,
    S_EMIT
  } state_e;

  state_e                   state_q;
  logic [ptes_pkg::CNT_W-1:0] cnt_q, u_q, kept_q, tgt_full;
  logic [ptes_pkg::IDX_W-1:0] tgt;

  ptes_pkg::rec_t rec [ptes_pkg::MAX_PARTICLES];
  ptes_pkg::rec_t head, new_rec, wr_rec, upd, work_q;
  ptes_pkg::cell_ctrl_t ctrl [ptes_pkg::MAX_PARTICLES];

  logic        out_free, in_acc, alive, shift_up, shift_dn, wr_en;
  logic        out_valid_q, last_q;
  logic [1:0]  status_q;
  logic [31:0] ox_q, oy_q, oz_q;
  logic [15:0] os_q;

  logic signed [16:0] diff;
  logic signed [33:0] prod, prod_q;
  logic [32:0]        mag;
  logic               neg_q;
  logic               div_done;
  logic [16:0]        quot;
  logic [17:0]        sq;
  logic [15:0]        scale_new;

  function automatic logic [ptes_pkg::CNT_W-1:0] CNT_W_ONE(input logic b);
    CNT_W_ONE = {{(ptes_pkg::CNT_W-1){1'b0}}, b};
  endfunction

  assign head     = rec[0];
  assign alive    = head.age < head.life;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign in_acc   = in_i.valid && in_i.ready;
  assign tgt_full = u_q + kept_q - 1'b1;
  assign tgt      = tgt_full[ptes_pkg::IDX_W-1:0];

  assign new_rec = '{age: 16'd0, life: in_i.life_frames, px: in_i.pos_x, py: in_i.pos_y,
                     pz: in_i.pos_z, vx: in_i.vel_x, vy: in_i.vel_y, vz: in_i.vel_z,
                     ax: in_i.acc_x, ay: in_i.acc_y, az: in_i.acc_z,
                     scale: in_i.scale_pair};

  assign shift_up = in_acc && (in_i.opcode == ptes_pkg::OP_ADD) &&
                    (cnt_q != ptes_pkg::CNT_W'(ptes_pkg::MAX_PARTICLES));
  assign shift_dn = ((state_q == S_SCAN) && (u_q != '0)) || ((state_q == S_EMIT) && out_free);
  assign wr_en    = (state_q == S_EMIT) || alive;
  assign wr_rec   = (state_q == S_EMIT) ? work_q : head;

  // Records that survive go to the back of the chain, behind the ones still waiting.
  for (genvar i = 0; i < ptes_pkg::MAX_PARTICLES; i++) begin : g_cell
    ptes_pkg::rec_t up_rec, dn_rec;
    if (i == 0) begin : g_first
      assign up_rec = new_rec;
    end else begin : g_mid
      assign up_rec = rec[i-1];
    end
    if (i == ptes_pkg::MAX_PARTICLES - 1) begin : g_last
      assign dn_rec = rec[i];
    end else begin : g_inner
      assign dn_rec = rec[i+1];
    end
    assign ctrl[i] = '{shift_up: shift_up, shift_dn: shift_dn,
                       wr_sel: wr_en && (tgt == ptes_pkg::IDX_W'(i))};
    ptes_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl[i]),
      .up_i   (up_rec),
      .dn_i   (dn_rec),
      .wr_i   (wr_rec),
      .rec_o  (rec[i])
    );
  end

  always_comb begin
    upd     = head;
    upd.age = head.age + 16'd1;
    upd.vx  = head.vx + head.ax;
    upd.vy  = head.vy + head.ay;
    upd.vz  = head.vz + head.az;
    upd.px  = head.px + upd.vx;
    upd.py  = head.py + upd.vy;
    upd.pz  = head.pz + upd.vz;
    diff    = $signed({head.scale[31], head.scale[31:16]}) -
              $signed({head.scale[15], head.scale[15:0]});
    prod    = diff * $signed({1'b0, upd.age});
  end

  assign mag       = prod_q[33] ? 33'(-prod_q) : prod_q[32:0];
  assign sq        = neg_q ? -{1'b0, quot} : {1'b0, quot};
  assign scale_new = work_q.scale[15:0] + sq[15:0];

  ptes_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DLD),
    .dividend_i (mag),
    .divisor_i  (work_q.life),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      work_q <= upd;
      prod_q <= prod;
      neg_q  <= prod[33];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      u_q         <= '0;
      kept_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ptes_pkg::ST_NONE;
      last_q      <= 1'b0;
      ox_q        <= '0;
      oy_q        <= '0;
      oz_q        <= '0;
      os_q        <= '0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (in_i.opcode == ptes_pkg::OP_ADD) begin
              out_valid_q <= 1'b1;
              last_q      <= 1'b1;
              ox_q        <= '0;
              oy_q        <= '0;
              oz_q        <= '0;
              os_q        <= '0;
              if (shift_up) begin
                cnt_q    <= cnt_q + 1'b1;
                status_q <= ptes_pkg::ST_ADD_OK;
              end else begin
                status_q <= ptes_pkg::ST_FULL;
              end
            end else begin
              u_q     <= cnt_q;
              kept_q  <= '0;
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (u_q != '0) begin
            u_q    <= u_q - 1'b1;
            kept_q <= kept_q + CNT_W_ONE(alive);
          end else if (kept_q != '0) begin
            cnt_q   <= kept_q;
            u_q     <= kept_q;
            kept_q  <= '0;
            state_q <= S_MUL;
          end else if (out_free) begin
            cnt_q       <= '0;
            out_valid_q <= 1'b1;
            status_q    <= ptes_pkg::ST_NONE;
            last_q      <= 1'b1;
            ox_q        <= '0;
            oy_q        <= '0;
            oz_q        <= '0;
            os_q        <= '0;
            state_q     <= S_IDLE;
          end
        end
        S_MUL: state_q <= S_DLD;
        S_DLD: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= ptes_pkg::ST_REC;
            last_q      <= (u_q == ptes_pkg::CNT_W'(1));
            ox_q        <= work_q.px;
            oy_q        <= work_q.py;
            oz_q        <= work_q.pz;
            os_q        <= scale_new;
            u_q         <= u_q - 1'b1;
            kept_q      <= kept_q + 1'b1;
            state_q     <= (u_q == ptes_pkg::CNT_W'(1)) ? S_IDLE : S_MUL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = status_q;
  assign out_o.out_x     = ox_q;
  assign out_o.out_y     = oy_q;
  assign out_o.out_z     = oz_q;
  assign out_o.out_scale = os_q;
  assign out_o.last      = last_q;

endmodule

@@ hw/rtl/ptes_check.sv @@
module ptes_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_opcode_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_status_i,
  input logic [31:0] out_x_i,
  input logic [15:0] out_scale_i,
  input logic        out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  a_add_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i == ptes_pkg::OP_ADD) |=>
      out_valid_i && out_last_i &&
      ((out_status_i == ptes_pkg::ST_ADD_OK) || (out_status_i == ptes_pkg::ST_FULL)))
    else $error("add beat without its status beat");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ptes_pkg::ST_REC) |-> out_last_i)
    else $error("status beat not marked last");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ptes_pkg::ST_REC) |->
      (out_x_i == '0) && (out_scale_i == '0))
    else $error("status beat carries nonzero payload");

endmodule

bind particle_table_euler_step_core ptes_check u_ptes_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_opcode_i  (in_i.opcode),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_x_i      (out_o.out_x),
  .out_scale_i  (out_o.out_scale),
  .out_last_i   (out_o.last)
);
